@@ design/sorted_priority_queue_top_macros.svh @@
// Assertion macros used by the sorted priority queue top level.
`ifndef SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SPQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ design/spq_pkg.sv @@
// Types and constants shared by the sorted priority queue modules.
package spq_pkg;

    localparam int VALUE_W      = 32;
    localparam int PRIO_W       = 8;
    localparam int COUNT_OUT_W  = 5;
    localparam int CAPACITY_DEF = 16;

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_PEEK = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctl;

endpackage

@@ design/spq_cell.sv @@
// One slot of the sorted queue: holds an entry and shifts with its neighbours.
module spq_cell (
    input  logic                                i_clk,
    input  spq_pkg::t_cell_ctl                  i_ctl,
    input  logic                                i_head,
    input  logic                                i_occupied,
    input  logic                                i_left_ins,
    input  logic signed [spq_pkg::VALUE_W-1:0]  i_left_value,
    input  logic        [spq_pkg::PRIO_W-1:0]   i_left_prio,
    input  logic signed [spq_pkg::VALUE_W-1:0]  i_right_value,
    input  logic        [spq_pkg::PRIO_W-1:0]   i_right_prio,
    input  logic signed [spq_pkg::VALUE_W-1:0]  i_new_value,
    input  logic        [spq_pkg::PRIO_W-1:0]   i_new_prio,
    output logic signed [spq_pkg::VALUE_W-1:0]  o_value,
    output logic        [spq_pkg::PRIO_W-1:0]   o_prio,
    output logic                                o_ins
);
    import spq_pkg::*;

    logic signed [VALUE_W-1:0] r_value;
    logic        [PRIO_W-1:0]  r_prio;
    logic                      w_beats;

    // The head gives way only to a strictly higher priority; later slots also
    // to an equal one, so a new item lands ahead of later entries of its priority.
    assign w_beats = i_head ? (r_prio < i_new_prio) : (r_prio <= i_new_prio);
    assign o_ins   = !i_occupied || w_beats;

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            if (i_left_ins) begin
                r_value <= i_left_value;
                r_prio  <= i_left_prio;
            end else if (o_ins) begin
                r_value <= i_new_value;
                r_prio  <= i_new_prio;
            end
        end else if (i_ctl.pop) begin
            r_value <= i_right_value;
            r_prio  <= i_right_prio;
        end
    end

    assign o_value = r_value;
    assign o_prio  = r_prio;

endmodule

@@ design/sorted_priority_queue_top.sv @@
// Top level of the sorted priority queue: a row of slot cells and the count.
//
//  Channel   Handshake         Fields
//  command   start / busy      i_operation, i_item_value, i_item_priority
//  result    o_valid strobe    o_head_value, o_status, o_entry_count, o_is_empty
//
// One item is taken every clock cycle; busy stays low.
// Each result appears in the cycle after its item, for one cycle only.
// All slots compare against the new priority at once, so a push or pop
// completes in the same cycle that the slot row shifts.
// Synchronous active-low reset empties the queue; there is no clearing pass.
`include "sorted_priority_queue_top_macros.svh"

module sorted_priority_queue_top #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic        [1:0]                       i_operation,
    input  logic signed [spq_pkg::VALUE_W-1:0]      i_item_value,
    input  logic        [spq_pkg::PRIO_W-1:0]       i_item_priority,
    output logic                                    o_valid,
    output logic signed [spq_pkg::VALUE_W-1:0]      o_head_value,
    output logic        [1:0]                       o_status,
    output logic        [spq_pkg::COUNT_OUT_W-1:0]  o_entry_count,
    output logic                                    o_is_empty
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic signed [VALUE_W-1:0] w_value [CAPACITY];
    logic        [PRIO_W-1:0]  w_prio  [CAPACITY];
    logic                      w_ins   [CAPACITY];

    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       n_count;
    logic                   r_valid;
    logic signed [VALUE_W-1:0] r_head;
    logic signed [VALUE_W-1:0] n_head;
    t_status                r_status;
    t_status                n_status;
    logic [COUNT_OUT_W-1:0] r_entry_count;
    logic                   r_is_empty;
    t_cell_ctl              w_ctl;
    t_op                    w_op;
    logic                   w_accept;
    logic                   w_full;
    logic                   w_empty;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_op     = t_op'(i_operation);
    assign w_full   = (r_count == CNT_W'(CAPACITY));
    assign w_empty  = (r_count == '0);

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic                      w_left_ins;
            logic signed [VALUE_W-1:0] w_left_value;
            logic        [PRIO_W-1:0]  w_left_prio;
            logic signed [VALUE_W-1:0] w_right_value;
            logic        [PRIO_W-1:0]  w_right_prio;
            logic                      w_occupied;

            if (g == 0) begin : g_first
                assign w_left_ins   = 1'b0;
                assign w_left_value = '0;
                assign w_left_prio  = '0;
            end else begin : g_mid
                assign w_left_ins   = w_ins[g-1];
                assign w_left_value = w_value[g-1];
                assign w_left_prio  = w_prio[g-1];
            end

            if (g == CAPACITY - 1) begin : g_last
                assign w_right_value = '0;
                assign w_right_prio  = '0;
            end else begin : g_inner
                assign w_right_value = w_value[g+1];
                assign w_right_prio  = w_prio[g+1];
            end

            assign w_occupied = (r_count > CNT_W'(g));

            spq_cell u_cell (
                .i_clk         (i_clk),
                .i_ctl         (w_ctl),
                .i_head        (g == 0),
                .i_occupied    (w_occupied),
                .i_left_ins    (w_left_ins),
                .i_left_value  (w_left_value),
                .i_left_prio   (w_left_prio),
                .i_right_value (w_right_value),
                .i_right_prio  (w_right_prio),
                .i_new_value   (i_item_value),
                .i_new_prio    (i_item_priority),
                .o_value       (w_value[g]),
                .o_prio        (w_prio[g]),
                .o_ins         (w_ins[g])
            );
        end
    endgenerate

    always_comb begin
        w_ctl    = '0;
        n_count  = r_count;
        n_head   = '0;
        n_status = ST_OK;
        unique case (w_op)
            OP_PUSH: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_ctl.push = w_accept;
                    n_count    = r_count + 1'b1;
                end
            end
            OP_POP: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_head    = w_value[0];
                    w_ctl.pop = w_accept;
                    n_count   = r_count - 1'b1;
                end
            end
            OP_PEEK: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_head = w_value[0];
                end
            end
            default: begin
                // The unused code leaves the queue alone and reports its state.
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_accept;
            if (w_accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_head        <= n_head;
            r_status      <= n_status;
            r_entry_count <= COUNT_OUT_W'(n_count);
            r_is_empty    <= (n_count == '0);
        end
    end

    assign o_valid       = r_valid;
    assign o_head_value  = r_head;
    assign o_status      = r_status;
    assign o_entry_count = r_entry_count;
    assign o_is_empty    = r_is_empty;

    `SPQ_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(CAPACITY))
    `SPQ_ASSERT_NOW(a_empty_flag, i_clk, i_rst_n, r_valid, r_is_empty == (r_count == '0))
    `SPQ_ASSERT_NOW(a_full_status, i_clk, i_rst_n, r_valid && (r_status == ST_FULL), r_count == CNT_W'(CAPACITY))
    `SPQ_ASSERT_NEXT(a_push_grows, i_clk, i_rst_n, w_accept && (w_op == OP_PUSH) && !w_full, r_count == $past(r_count) + 1'b1)

endmodule
